// ===== rtl/core/svf_pkg.sv =====
// ----------------------------------------------------------------------------
// svf_pkg
// Shared widths, limits, register codes and sequencer states of the
// state-variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

    // channel count and sample format
    localparam int CHANNELS   = 2;
    localparam int SAMPLE_W   = 16;
    localparam int STATE_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int FREQ_W     = 15;
    localparam int DAMP_W     = 14;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 15'd23170;
    localparam logic [DAMP_W-1:0] DAMP_MAX = 14'd8192;

    // shared multiplier: signal operand times coefficient or gain
    localparam int MUL_A_W = STATE_W + 1;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_COEFF   = 3'd0,
        REG_DAMPING      = 3'd1,
        REG_LOWPASS_GAIN = 3'd2,
        REG_BANDPASS_GAIN = 3'd3,
        REG_HIGHPASS_GAIN = 3'd4,
        REG_ACCUM_ENABLE = 3'd5
    } cfg_reg_t;

    // sequencer states, one multiply issued in each MUL state
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_FD,
        S_MUL_QD,
        S_MUL_LP,
        S_MUL_FH,
        S_MUL_HP,
        S_MUL_BP,
        S_MIX,
        S_DONE
    } svf_state_t;

    // request to the shared multiplier
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

endpackage

// ===== rtl/core/svf_if.sv =====
// ----------------------------------------------------------------------------
// svf_if
// Valid/ready channels of the filter: sample requests in, results out.
// ----------------------------------------------------------------------------
interface svf_in_if;
    import svf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic signed [SAMPLE_W-1:0] accumulate_in;

    modport source (output valid, output channel, output sample_in,
                    output accumulate_in, input ready);
    modport sink (input valid, input channel, input sample_in,
                  input accumulate_in, output ready);
endinterface

interface svf_out_if;
    import svf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       out_channel;

    modport source (output valid, output sample_out, output out_channel,
                    input ready);
    modport sink (input valid, input sample_out, input out_channel,
                  output ready);
endinterface

// ===== rtl/core/svf_mul.sv =====
// ----------------------------------------------------------------------------
// svf_mul
// Shared signed multiplier with a registered product, one request a cycle.
// ----------------------------------------------------------------------------
module svf_mul
    import svf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mul_req_t                 req,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    // full-precision product
    assign prod_next = PROD_W'(req.a) * PROD_W'(req.b);

    // product register, held when no request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
        end
        else if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/state_variable_filter_12db.sv =====
// ----------------------------------------------------------------------------
// state_variable_filter_12db
// Resonant 12 dB/oct state-variable filter with per-channel integrators.
// ----------------------------------------------------------------------------
// Each request carries one Q1.15 sample of one channel. From acceptance to
// a loaded result, six multiplies (f*band, q*band, low*lp, f*high,
// high*hp, band*bp) go one per cycle through a single 33x17 multiplier with
// a registered product, followed by a mix step that adds the last product
// and a done step that rounds, saturates and loads the result. A new request
// is taken only while the sequencer is idle, which it enters at the edge that
// loads the result, so a request is not taken before the last one's result
// is loaded. A finished result waits in an output register, and the
// sequencer holds in its last step while that register is full and not
// being read. Coefficients above their caps are clamped when written.
// Configuration writes are taken at any time but are meant for idle time.
module state_variable_filter_12db
    import svf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    svf_in_if.sink                samples,
    svf_out_if.source             results
);

    // configuration registers
    logic [FREQ_W-1:0]          freq_reg;
    logic [DAMP_W-1:0]          damp_reg;
    logic signed [SAMPLE_W-1:0] lp_gain_reg;
    logic signed [SAMPLE_W-1:0] bp_gain_reg;
    logic signed [SAMPLE_W-1:0] hp_gain_reg;
    logic                       accum_en_reg;

    // integrator state
    logic signed [STATE_W-1:0]  band_state_reg [CHANNELS];
    logic signed [STATE_W-1:0]  low_state_reg  [CHANNELS];

    // sequencer
    svf_state_t                 state_reg;
    svf_state_t                 state_next;

    // captured request and working values
    logic                       ch_reg;
    logic                       ch_ok_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] acc_reg;
    logic signed [STATE_W-1:0]  d1_reg;
    logic signed [STATE_W-1:0]  d2_reg;
    logic signed [STATE_W-1:0]  low_reg;
    logic signed [STATE_W-1:0]  high_reg;
    logic signed [STATE_W-1:0]  band_reg;
    logic signed [PROD_W+1:0]   mix_reg;

    // output register
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic                       out_channel_reg;

    // datapath signals
    mul_req_t                   mul_req;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;
    logic signed [35:0]         prod_r14;
    logic signed [39:0]         low_sum;
    logic signed [39:0]         high_sum;
    logic signed [39:0]         band_sum;
    logic signed [PROD_W+1:0]   mix_rnd;
    logic signed [39:0]         mix_r12;
    logic signed [40:0]         final_sum;
    logic signed [STATE_W-1:0]  d1_sel;
    logic signed [STATE_W-1:0]  d2_sel;
    logic                       accept;
    logic                       out_free;

    // saturate to a signed width
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [40:0] v);
        if (v > 41'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -41'sh0_8000_0000)
            return -32'sh8000_0000;
        else
            return v[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [40:0] v);
        if (v > 41'sd32767)
            return 16'sh7FFF;
        else if (v < -41'sd32768)
            return -16'sh8000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    // state read for the incoming channel
    always_comb
    begin
        d1_sel = '0;
        d2_sel = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (int'(samples.channel) == c)
            begin
                d1_sel = band_state_reg[c];
                d2_sel = low_state_reg[c];
            end
        end
    end

    // rounding of the registered product at 14 fractional bits
    assign prod_rnd = prod + PROD_W'(8192);
    assign prod_r14 = prod_rnd[PROD_W-1:14];

    // integrator updates
    assign low_sum  = 40'(d2_reg) + 40'(prod_r14);
    assign high_sum = 40'(x_reg >>> 1) - 40'(low_reg) - 40'(prod_r14);
    assign band_sum = 40'(d1_reg) + 40'(prod_r14);

    // final rounding at 12 fractional bits, optional accumulate
    assign mix_rnd   = mix_reg + (PROD_W+2)'(2048);
    assign mix_r12   = ch_ok_reg ? mix_rnd[PROD_W+1:12] : 40'sd0;
    assign final_sum = 41'(mix_r12) + (accum_en_reg ? 41'(acc_reg) : 41'sd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_MUL_FD;
            S_MUL_FD: state_next = S_MUL_QD;
            S_MUL_QD: state_next = S_MUL_LP;
            S_MUL_LP: state_next = S_MUL_FH;
            S_MUL_FH: state_next = S_MUL_HP;
            S_MUL_HP: state_next = S_MUL_BP;
            S_MUL_BP: state_next = S_MIX;
            S_MIX:    state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // multiplier requests per step
    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        case (state_reg)
            S_MUL_FD:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(d1_reg);
                mul_req.b  = MUL_B_W'($signed({1'b0, freq_reg}));
            end
            S_MUL_QD:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(d1_reg);
                mul_req.b  = MUL_B_W'($signed({1'b0, damp_reg}));
            end
            S_MUL_LP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(low_reg);
                mul_req.b  = MUL_B_W'(lp_gain_reg);
            end
            S_MUL_FH:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(high_reg);
                mul_req.b  = MUL_B_W'($signed({1'b0, freq_reg}));
            end
            S_MUL_HP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(high_reg);
                mul_req.b  = MUL_B_W'(hp_gain_reg);
            end
            S_MUL_BP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(band_reg);
                mul_req.b  = MUL_B_W'(bp_gain_reg);
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    svf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .prod  (prod)
    );

    // sequencer register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes, caps applied on write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg     <= 15'd561;
            damp_reg     <= 14'd8192;
            lp_gain_reg  <= 16'sd4096;
            bp_gain_reg  <= '0;
            hp_gain_reg  <= '0;
            accum_en_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_FREQ_COEFF:
                    freq_reg <= (cfg_data[FREQ_W-1:0] > FREQ_MAX) ?
                                FREQ_MAX : cfg_data[FREQ_W-1:0];
                REG_DAMPING:
                    damp_reg <= (cfg_data[DAMP_W-1:0] > DAMP_MAX) ?
                                DAMP_MAX : cfg_data[DAMP_W-1:0];
                REG_LOWPASS_GAIN:  lp_gain_reg  <= $signed(cfg_data);
                REG_BANDPASS_GAIN: bp_gain_reg  <= $signed(cfg_data);
                REG_HIGHPASS_GAIN: hp_gain_reg  <= $signed(cfg_data);
                REG_ACCUM_ENABLE:  accum_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // integrator state, written back at the end of the mix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                band_state_reg[c] <= '0;
                low_state_reg[c]  <= '0;
            end
        end
        else if (state_reg == S_MIX && ch_ok_reg)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (int'(ch_reg) == c)
                begin
                    band_state_reg[c] <= band_reg;
                    low_state_reg[c]  <= low_reg;
                end
            end
        end
    end

    // request capture and working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= samples.channel;
            ch_ok_reg <= int'(samples.channel) < CHANNELS;
            x_reg     <= samples.sample_in;
            acc_reg   <= samples.accumulate_in;
            d1_reg    <= d1_sel;
            d2_reg    <= d2_sel;
        end
        case (state_reg)
            S_MUL_QD: low_reg  <= sat32(41'(low_sum));
            S_MUL_LP: high_reg <= sat32(41'(high_sum));
            S_MUL_FH: mix_reg  <= (PROD_W+2)'(prod);
            S_MUL_HP: band_reg <= sat32(41'(band_sum));
            S_MUL_BP: mix_reg  <= mix_reg + (PROD_W+2)'(prod);
            S_MIX:    mix_reg  <= mix_reg + (PROD_W+2)'(prod);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            sample_out_reg  <= sat16(final_sum);
            out_channel_reg <= ch_reg;
        end
    end

    assign samples.ready       = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.sample_out  = sample_out_reg;
    assign results.out_channel = out_channel_reg;

endmodule

// ===== tb/tb_state_variable_filter_12db.sv =====
// ============================================================================
// tb_state_variable_filter_12db
// Self-checking bench for the two-channel 12 dB/oct state-variable filter.
// A directed table covers the reset state, accumulate mode, coefficient
// clamping, unused register indexes and the sample and gain extremes. After
// it come randomized phases, each with its own coefficient and gain set.
// Results are compared to a cycle-free model of integrators and output mix,
// or to a row's known value. Both handshakes idle and stall at random.
// ============================================================================
module tb_state_variable_filter_12db;
    import svf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // indexes that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int NUM_PHASES      = 18;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int DRAIN_CYCLES    = 30;
    localparam int CYCLE_LIMIT     = 300000;

    typedef struct packed {
        logic                       is_cfg;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      data;
        logic                       ch;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] acc;
        logic                       known;
        logic signed [SAMPLE_W-1:0] want;
    } test_row_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } out_item_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    svf_in_if  sample_bus ();
    svf_out_if result_bus ();

    // model copy of the registers and integrators
    logic [FREQ_W-1:0]          model_freq;
    logic [DAMP_W-1:0]          model_damp;
    logic signed [SAMPLE_W-1:0] model_lp_gain;
    logic signed [SAMPLE_W-1:0] model_bp_gain;
    logic signed [SAMPLE_W-1:0] model_hp_gain;
    logic                       model_accum;
    logic signed [STATE_W-1:0]  band_state [CHANNELS];
    logic signed [STATE_W-1:0]  low_state [CHANNELS];

    out_item_t pending_outputs [$];
    bit        no_idle = 1'b0;
    int        fail_count = 0;
    int        outputs_checked = 0;
    int        samples_sent = 0;
    int        settings_used = 0;
    int        cycle_count = 0;

    test_row_t directed_rows [30];

    state_variable_filter_12db DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_bus),
        .results   (result_bus)
    );

    always #5ns clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("state_variable_filter_12db verification failed");
            $finish;
        end
    end

    // arithmetic helpers
    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat_state(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one filter step on the model state, returns the expected output sample
    function automatic logic signed [SAMPLE_W-1:0] next_filter_output(
        logic ch, logic signed [SAMPLE_W-1:0] x, logic signed [SAMPLE_W-1:0] acc);
        longint f, q, d1, d2, lo, hi, bd, mix;
        f = (model_freq > FREQ_MAX) ? FREQ_MAX : model_freq;
        q = (model_damp > DAMP_MAX) ? DAMP_MAX : model_damp;
        d1 = band_state[ch];
        d2 = low_state[ch];
        lo = sat_state(d2 + round_half_up(f * d1, 14));
        hi = sat_state((longint'(x) >>> 1) - lo - round_half_up(q * d1, 14));
        bd = sat_state(d1 + round_half_up(f * hi, 14));
        mix = lo * longint'(model_lp_gain) + bd * longint'(model_bp_gain)
            + hi * longint'(model_hp_gain);
        mix = round_half_up(mix, 12);
        band_state[ch] = bd[STATE_W-1:0];
        low_state[ch] = lo[STATE_W-1:0];
        if (model_accum)
            mix = mix + longint'(acc);
        if (mix > 32767)
            return 16'sh7FFF;
        if (mix < -32768)
            return 16'sh8000;
        return mix[SAMPLE_W-1:0];
    endfunction

    // table row builders
    function automatic test_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        return '{1'b1, idx, data, 1'b0, 16'sd0, 16'sd0, 1'b0, 16'sd0};
    endfunction

    function automatic test_row_t smp_row(logic ch, logic signed [SAMPLE_W-1:0] x,
                                          logic signed [SAMPLE_W-1:0] acc);
        return '{1'b0, REG_FREQ_COEFF, 16'h0000, ch, x, acc, 1'b0, 16'sd0};
    endfunction

    function automatic test_row_t known_row(logic ch, logic signed [SAMPLE_W-1:0] x,
                                            logic signed [SAMPLE_W-1:0] acc,
                                            logic signed [SAMPLE_W-1:0] want);
        return '{1'b0, REG_FREQ_COEFF, 16'h0000, ch, x, acc, 1'b1, want};
    endfunction

    // random register value, extremes and out-of-cap values weighted in
    function automatic logic [CFG_DATA_W-1:0] pick_cfg_value(cfg_reg_t which);
        int pick;
        pick = $urandom_range(0, 5);
        case (which)
            REG_FREQ_COEFF:
                case (pick)
                    0: return 16'd0;
                    1: return 16'(FREQ_MAX);
                    2: return 16'(32'($urandom_range(23171, 32767)) | (32'($urandom) & 32'h8000));
                    3: return 16'($urandom);
                    default: return 16'($urandom_range(1, 4000));
                endcase
            REG_DAMPING:
                case (pick)
                    0: return 16'd0;
                    1: return 16'(DAMP_MAX);
                    2: return 16'(32'($urandom_range(8193, 16383)) | (32'($urandom) & 32'hC000));
                    3: return 16'($urandom);
                    default: return 16'($urandom_range(500, 8192));
                endcase
            REG_ACCUM_ENABLE:
                return 16'($urandom);
            default:
                case (pick)
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'($urandom);
                    default: return 16'(int'($urandom_range(0, 8192)) - 4096);
                endcase
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2, 3: return 16'(int'($urandom_range(0, 511)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // register write, only once every pending output has come back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        sample_bus.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_FREQ_COEFF:    model_freq = data[FREQ_W-1:0];
            REG_DAMPING:       model_damp = data[DAMP_W-1:0];
            REG_LOWPASS_GAIN:  model_lp_gain = data;
            REG_BANDPASS_GAIN: model_bp_gain = data;
            REG_HIGHPASS_GAIN: model_hp_gain = data;
            REG_ACCUM_ENABLE:  model_accum = data[0];
            default: ;
        endcase
    endtask

    // one sample request; valid stays high on return so back-to-back works
    task automatic send_sample(logic ch, logic signed [SAMPLE_W-1:0] x,
                               logic signed [SAMPLE_W-1:0] acc, logic known,
                               logic signed [SAMPLE_W-1:0] want);
        int gap;
        out_item_t item;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        cfg_wr_en <= 1'b0;
        if (gap != 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.channel <= ch;
        sample_bus.sample_in <= x;
        sample_bus.accumulate_in <= acc;
        @(negedge clk);
        while (!sample_bus.ready)
            @(negedge clk);
        @(posedge clk);
        item.sample = next_filter_output(ch, x, acc);
        if (known)
            item.sample = want;
        item.channel = ch;
        pending_outputs.push_back(item);
        samples_sent++;
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial
    begin
        int stall;
        out_item_t got;
        out_item_t exp_item;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall != 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(negedge clk);
            while (!result_bus.valid)
                @(negedge clk);
            got.sample = result_bus.sample_out;
            got.channel = result_bus.out_channel;
            @(posedge clk);
            if (pending_outputs.size() == 0)
            begin
                $error("unexpected output: sample_out %0d out_channel %0d",
                       got.sample, got.channel);
                fail_count++;
            end
            else
            begin
                exp_item = pending_outputs.pop_front();
                outputs_checked++;
                if (got.sample !== exp_item.sample)
                begin
                    $error("sample_out expected %0d actual %0d",
                           exp_item.sample, got.sample);
                    fail_count++;
                end
                if (got.channel !== exp_item.channel)
                begin
                    $error("out_channel expected %0d actual %0d",
                           exp_item.channel, got.channel);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        test_row_t row;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_FREQ_COEFF;
        cfg_data <= '0;
        sample_bus.valid <= 1'b0;
        sample_bus.channel <= 1'b0;
        sample_bus.sample_in <= '0;
        sample_bus.accumulate_in <= '0;

        model_freq = 15'd561;
        model_damp = 14'd8192;
        model_lp_gain = 16'sd4096;
        model_bp_gain = 16'sd0;
        model_hp_gain = 16'sd0;
        model_accum = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            band_state[c] = '0;
            low_state[c] = '0;
        end

        // with zero integrators the low output, the only mixed path after
        // reset, is zero; with all gains at zero only accumulate_in comes out
        directed_rows = '{
            known_row(1'b0, 16'sd0, 16'sd0, 16'sd0),
            known_row(1'b1, 16'sh7FFF, 16'sd12345, 16'sd0),
            known_row(1'b0, 16'sh8000, -16'sd1, 16'sd0),
            smp_row(1'b1, 16'sd1000, 16'sd0),
            cfg_row(REG_ACCUM_ENABLE, 16'h0001),
            cfg_row(REG_LOWPASS_GAIN, 16'h0000),
            known_row(1'b0, 16'sh7FFF, 16'sh8000, 16'sh8000),
            known_row(1'b1, 16'sh8000, 16'sh7FFF, 16'sh7FFF),
            known_row(1'b0, -16'sd1, 16'sh5555, 16'sh5555),
            cfg_row(REG_FREQ_COEFF, 16'hFFFF),
            cfg_row(REG_DAMPING, 16'hFFFF),
            cfg_row(REG_LOWPASS_GAIN, 16'h8000),
            cfg_row(REG_BANDPASS_GAIN, 16'h7FFF),
            cfg_row(REG_HIGHPASS_GAIN, 16'h8000),
            cfg_row(REG_SPARE_LO, 16'h1234),
            cfg_row(REG_SPARE_HI, 16'hFFFF),
            smp_row(1'b0, 16'sh7FFF, 16'sh7FFF),
            smp_row(1'b1, 16'sh8000, 16'sh8000),
            smp_row(1'b0, 16'sh8000, 16'sd0),
            smp_row(1'b0, 16'sh7FFF, -16'sd1),
            cfg_row(REG_ACCUM_ENABLE, 16'hFFFE),
            cfg_row(REG_FREQ_COEFF, 16'h0000),
            cfg_row(REG_DAMPING, 16'h0000),
            cfg_row(REG_HIGHPASS_GAIN, 16'h7FFF),
            smp_row(1'b1, 16'sh7FFF, 16'sd0),
            smp_row(1'b0, 16'sh8000, 16'sd0),
            cfg_row(REG_FREQ_COEFF, 16'(FREQ_MAX)),
            cfg_row(REG_DAMPING, 16'(DAMP_MAX)),
            smp_row(1'b1, 16'sh2AAA, 16'sd0),
            smp_row(1'b0, 16'shD555, 16'sd0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
                write_reg(row.idx, row.data);
            else
                send_sample(row.ch, row.x, row.acc, row.known, row.want);
        end
        settings_used = 5;

        // random phases, a fresh register set each
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_reg(REG_FREQ_COEFF, pick_cfg_value(REG_FREQ_COEFF));
            write_reg(REG_DAMPING, pick_cfg_value(REG_DAMPING));
            write_reg(REG_LOWPASS_GAIN, pick_cfg_value(REG_LOWPASS_GAIN));
            write_reg(REG_BANDPASS_GAIN, pick_cfg_value(REG_BANDPASS_GAIN));
            write_reg(REG_HIGHPASS_GAIN, pick_cfg_value(REG_HIGHPASS_GAIN));
            write_reg(REG_ACCUM_ENABLE, pick_cfg_value(REG_ACCUM_ENABLE));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          16'($urandom));
            no_idle = (phase % 4 == 3);
            settings_used++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(1'($urandom_range(0, 1)), pick_sample(), pick_sample(),
                            1'b0, 16'sd0);
        end
        sample_bus.valid <= 1'b0;
        cfg_wr_en <= 1'b0;

        // drain, then go on waiting to catch stray outputs
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            $error("%0d expected outputs never arrived", pending_outputs.size());
            fail_count++;
        end

        $display("%0d sample requests over %0d register settings, %0d outputs compared",
                 samples_sent, settings_used, outputs_checked);
        $display("%0d failures seen", fail_count);
        if (fail_count == 0)
            $display("state_variable_filter_12db verification clean");
        else
            $display("state_variable_filter_12db verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/svf_pkg.sv
rtl/core/svf_if.sv
rtl/core/svf_mul.sv
rtl/core/state_variable_filter_12db.sv
tb/tb_state_variable_filter_12db.sv
